>>> src/ect_pkg.sv
package ect_pkg;

  localparam int NameMax    = 32;
  localparam int MaxResults = 5;

  typedef logic [2:0] res_cnt_t;

  typedef enum logic [3:0] {
    M_IDLE, M_DEC, M_HEX, M_BIN, M_STR, M_EQ, M_BANG, M_LT, M_GT, M_AT, M_VAR
  } lex_mode_t;

  typedef enum logic [4:0] {
    K_END = 5'd0, K_CONST = 5'd1, K_PLUS = 5'd2, K_MINUS = 5'd3, K_MUL = 5'd4,
    K_DIV = 5'd5, K_LPAR = 5'd6, K_RPAR = 5'd7, K_AND = 5'd8, K_OR = 5'd9,
    K_XOR = 5'd10, K_MOD = 5'd11, K_NOT = 5'd12, K_LT = 5'd13, K_LE = 5'd14,
    K_SHL = 5'd15, K_GT = 5'd16, K_GE = 5'd17, K_SHR = 5'd18, K_EQ = 5'd19,
    K_NE = 5'd20, K_AT = 5'd21, K_VCHAR = 5'd22, K_VEND = 5'd23, K_ERR = 5'd24
  } kind_t;

  typedef enum logic [2:0] {
    S_OK = 3'd0, S_MISSING = 3'd1, S_SYNTAX = 3'd2, S_BADVAR = 3'd3, S_PARENS = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0, SZ_WORD = 2'd1, SZ_LONG = 2'd2
  } size_t_t;

  typedef struct packed {
    lex_mode_t   mode;
    logic [31:0] acc;
    logic [15:0] bal;
    logic [5:0]  nlen;
    logic [3:0]  atsz;
    logic        drop;
  } lex_state_t;

  localparam lex_state_t LexClear = '{mode: M_IDLE, acc: 32'd0, bal: 16'd0,
                                      nlen: 6'd0, atsz: 4'd2, drop: 1'b0};

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    size_t_t     size_class;
    status_t     status;
    logic        expr_done;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    tok_t [MaxResults-1:0] items;
    res_cnt_t              n;
  } tok_list_t;

endpackage

>>> src/ect_chan_if.sv
interface ect_in_if import ect_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;
  modport source (output valid, ch, end_of_text, input ready);
  modport sink (input valid, ch, end_of_text, output ready);
endinterface

interface ect_out_if import ect_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [31:0] value;
  logic [1:0]  size_class;
  logic [2:0]  status;
  logic        expr_done;
  logic        last_of_run;
  modport source (output valid, kind, value, size_class, status, expr_done, last_of_run,
                  input ready);
  modport sink (input valid, kind, value, size_class, status, expr_done, last_of_run,
                output ready);
endinterface

interface ect_cfg_if import ect_pkg::*; ();
  logic valid;
  logic ready;
  logic crlf_as_space;
  modport source (output valid, crlf_as_space, input ready);
  modport sink (input valid, crlf_as_space, output ready);
endinterface

>>> src/ect_lex.sv
module ect_lex import ect_pkg::*; (
  input  lex_state_t st_i,
  input  logic [7:0] ch_i,
  input  logic       eot_i,
  input  logic       crlf_i,
  output lex_state_t st_o,
  output tok_list_t  list_o
);

  function automatic tok_t mk(kind_t k, logic [31:0] v, size_t_t sz, status_t s, logic d);
    tok_t t;
    t.kind = k; t.value = v; t.size_class = sz; t.status = s;
    t.expr_done = d; t.last_of_run = 1'b0;
    return t;
  endfunction

  function automatic tok_list_t push(tok_list_t l, tok_t t);
    tok_list_t r;
    r = l;
    if (l.n < res_cnt_t'(MaxResults)) begin
      r.items[l.n] = t;
      r.n = l.n + 3'd1;
    end
    return r;
  endfunction

  function automatic tok_t const_tok(logic [31:0] a);
    size_t_t sz;
    if (a <= 32'hff) sz = SZ_BYTE;
    else if (a <= 32'hffff) sz = SZ_WORD;
    else sz = SZ_LONG;
    return mk(K_CONST, a, sz, S_OK, 1'b0);
  endfunction

  logic       is_dig, is_alpha, is_start, is_hex;
  logic [3:0] hex_v;
  logic [31:0] vchar;

  always_comb begin
    is_dig   = ch_i inside {["0":"9"]};
    is_alpha = ch_i inside {["a":"z"], ["A":"Z"]};
    is_start = is_alpha || ch_i == 8'h7f || ch_i == "_" || ch_i == ".";
    is_hex   = is_dig || ch_i inside {["a":"f"], ["A":"F"]};
    hex_v    = is_dig ? ch_i[3:0] : ch_i[3:0] + 4'd9;
    vchar    = (ch_i == ".") ? 32'h7f : {24'd0, ch_i};
  end

  lex_state_t s;
  tok_list_t  l;
  logic       do_idle;

  always_comb begin
    s = st_i;
    l = '0;
    do_idle = 1'b0;
    if (st_i.drop) begin
      if (eot_i) s = LexClear;
    end else begin
      case (st_i.mode)
        M_DEC: begin
          if (is_dig) s.acc = (st_i.acc << 3) + (st_i.acc << 1) + {28'd0, ch_i[3:0]};
          else begin
            l = push(l, const_tok(st_i.acc)); s.acc = '0; do_idle = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hex) s.acc = {st_i.acc[27:0], hex_v};
          else if (ch_i != "_") begin
            l = push(l, const_tok(st_i.acc)); s.acc = '0; do_idle = 1'b1;
          end
        end
        M_BIN: begin
          if (ch_i == "0" || ch_i == "1") s.acc = {st_i.acc[30:0], ch_i[0]};
          else if (ch_i != "_") begin
            l = push(l, const_tok(st_i.acc)); s.acc = '0; do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (ch_i == "'") begin
            l = push(l, const_tok(st_i.acc)); s.acc = '0; s.mode = M_IDLE;
          end else if (ch_i == 8'd0) begin
            l = push(l, mk(K_ERR, '0, SZ_BYTE, S_SYNTAX, 1'b1));
            s.drop = 1'b1; s.mode = M_IDLE;
          end else s.acc = {st_i.acc[23:0], ch_i};
        end
        M_EQ, M_BANG: begin
          if (ch_i == "=") begin
            l = push(l, mk((st_i.mode == M_EQ) ? K_EQ : K_NE, '0, SZ_BYTE, S_OK, 1'b0));
            s.mode = M_IDLE;
          end else begin
            l = push(l, mk(K_ERR, '0, SZ_BYTE, S_MISSING, 1'b1));
            s.drop = 1'b1; s.mode = M_IDLE;
          end
        end
        M_LT: begin
          s.mode = M_IDLE;
          if (ch_i == "<") l = push(l, mk(K_SHL, '0, SZ_BYTE, S_OK, 1'b0));
          else if (ch_i == "=") l = push(l, mk(K_LE, '0, SZ_BYTE, S_OK, 1'b0));
          else begin
            l = push(l, mk(K_LT, '0, SZ_BYTE, S_OK, 1'b0)); do_idle = 1'b1;
          end
        end
        M_GT: begin
          s.mode = M_IDLE;
          if (ch_i == ">") l = push(l, mk(K_SHR, '0, SZ_BYTE, S_OK, 1'b0));
          else if (ch_i == "=") l = push(l, mk(K_GE, '0, SZ_BYTE, S_OK, 1'b0));
          else begin
            l = push(l, mk(K_GT, '0, SZ_BYTE, S_OK, 1'b0)); do_idle = 1'b1;
          end
        end
        M_AT: begin
          if (ch_i == "(") begin
            l = push(l, mk(K_AT, {28'd0, st_i.atsz}, SZ_BYTE, S_OK, 1'b0));
            s.bal = st_i.bal + 16'd1; s.mode = M_IDLE;
          end else if (is_dig) s.atsz = ch_i[3:0];
        end
        M_VAR: begin
          if ((is_start || is_dig) && st_i.nlen < 6'(NameMax)) begin
            l = push(l, mk(K_VCHAR, vchar, SZ_BYTE, S_OK, 1'b0));
            s.nlen = st_i.nlen + 6'd1;
          end else begin
            l = push(l, mk(K_VEND, '0, SZ_BYTE, S_OK, 1'b0));
            s.nlen = '0; do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        s.mode = M_IDLE;
        case (ch_i)
          " ", 8'h09: ;
          8'h0a, 8'h0d: if (!crlf_i) l = push(l, mk(K_END, '0, SZ_BYTE, S_OK, 1'b0));
          8'h00: l = push(l, mk(K_END, '0, SZ_BYTE, S_OK, 1'b0));
          "'": begin s.acc = '0; s.mode = M_STR; end
          "$": begin s.acc = '0; s.mode = M_HEX; end
          "%": begin s.acc = '0; s.mode = M_BIN; end
          "=": s.mode = M_EQ;
          "!": s.mode = M_BANG;
          "<": s.mode = M_LT;
          ">": s.mode = M_GT;
          "+": l = push(l, mk(K_PLUS, '0, SZ_BYTE, S_OK, 1'b0));
          "-": l = push(l, mk(K_MINUS, '0, SZ_BYTE, S_OK, 1'b0));
          "*": l = push(l, mk(K_MUL, '0, SZ_BYTE, S_OK, 1'b0));
          "/": l = push(l, mk(K_DIV, '0, SZ_BYTE, S_OK, 1'b0));
          "(": begin
            l = push(l, mk(K_LPAR, '0, SZ_BYTE, S_OK, 1'b0)); s.bal = s.bal + 16'd1;
          end
          ")": begin
            l = push(l, mk(K_RPAR, '0, SZ_BYTE, S_OK, 1'b0)); s.bal = s.bal - 16'd1;
          end
          "&": l = push(l, mk(K_AND, '0, SZ_BYTE, S_OK, 1'b0));
          "|": l = push(l, mk(K_OR, '0, SZ_BYTE, S_OK, 1'b0));
          "^": l = push(l, mk(K_XOR, '0, SZ_BYTE, S_OK, 1'b0));
          "\\": l = push(l, mk(K_MOD, '0, SZ_BYTE, S_OK, 1'b0));
          "~": l = push(l, mk(K_NOT, '0, SZ_BYTE, S_OK, 1'b0));
          "@": begin s.atsz = 4'd2; s.mode = M_AT; end
          default: begin
            if (is_dig) begin
              s.acc = {28'd0, ch_i[3:0]}; s.mode = M_DEC;
            end else if (is_start) begin
              l = push(l, mk(K_VCHAR, vchar, SZ_BYTE, S_OK, 1'b0));
              s.nlen = 6'd1; s.mode = M_VAR;
            end else begin
              l = push(l, mk(K_ERR, '0, SZ_BYTE, S_BADVAR, 1'b1));
              s.drop = 1'b1;
            end
          end
        endcase
      end

      if (eot_i) begin
        // close whatever token is still pending
        if (!s.drop) begin
          case (s.mode)
            M_DEC, M_HEX, M_BIN: l = push(l, const_tok(s.acc));
            M_STR, M_AT: begin
              l = push(l, mk(K_ERR, '0, SZ_BYTE, S_SYNTAX, 1'b1)); s.drop = 1'b1;
            end
            M_EQ, M_BANG: begin
              l = push(l, mk(K_ERR, '0, SZ_BYTE, S_MISSING, 1'b1)); s.drop = 1'b1;
            end
            M_LT: l = push(l, mk(K_LT, '0, SZ_BYTE, S_OK, 1'b0));
            M_GT: l = push(l, mk(K_GT, '0, SZ_BYTE, S_OK, 1'b0));
            M_VAR: l = push(l, mk(K_VEND, '0, SZ_BYTE, S_OK, 1'b0));
            default: ;
          endcase
        end
        if (!s.drop) begin
          l = push(l, mk(K_END, '0, SZ_BYTE, S_OK, 1'b0));
          if (s.bal != 16'd0) l = push(l, mk(K_ERR, '0, SZ_BYTE, S_PARENS, 1'b1));
          else if (l.n != 3'd0) l.items[l.n - 3'd1].expr_done = 1'b1;
        end
        s = LexClear;
      end
    end
    if (l.n != 3'd0) l.items[l.n - 3'd1].last_of_run = 1'b1;
  end

  assign st_o   = s;
  assign list_o = l;

endmodule

>>> src/expression_char_tokenizer.sv
// expression character tokenizer
//
// in_chan  : one character per request (ch, end_of_text), valid/ready
// out_chan : tokens (kind, value, size_class, status, expr_done, last_of_run)
// cfg_chan : crlf_as_space, always ready; write it only while the block is idle
//
// a character is lexed in the cycle it is accepted and all the tokens it
// causes (none to five) land in a small result buffer; the first token is
// shown on out_chan in the next cycle
// throughput: one character per cycle while each character yields at most
// one token and out_chan is ready; a character yielding several tokens holds
// the input as the buffer drains them, one per cycle while out_chan is ready, to the single output port
// a character yielding no token is taken and leaves the output untouched
// when the receiver stalls the buffer holds and in_chan.ready drops until
// the last buffered token is being taken
// reset clears the lexer state, the buffer pointers and crlf_as_space
module expression_char_tokenizer import ect_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ect_in_if.sink    in_chan,
  ect_out_if.source out_chan,
  ect_cfg_if.sink   cfg_chan
);

  // lexer state and config
  lex_state_t st_r, st_nxt;
  logic       crlf_r;

  // token buffer: head_r walks up to cnt_r
  tok_t [MaxResults-1:0] items_r;
  res_cnt_t              cnt_r, head_r;
  tok_list_t             list_nxt;

  logic in_fire, out_fire, buf_busy;
  tok_t cur;

  ect_lex u_lex (
    .st_i   (st_r),
    .ch_i   (in_chan.ch),
    .eot_i  (in_chan.end_of_text),
    .crlf_i (crlf_r),
    .st_o   (st_nxt),
    .list_o (list_nxt)
  );

  assign buf_busy = head_r != cnt_r;
  assign out_fire = buf_busy && out_chan.ready;
  // take a new character once the last buffered token leaves
  assign in_chan.ready = !buf_busy || (out_fire && (head_r + 3'd1 == cnt_r));
  assign in_fire = in_chan.valid && in_chan.ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      crlf_r <= cfg_chan.crlf_as_space;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LexClear;
      cnt_r  <= '0;
      head_r <= '0;
    end else if (in_fire) begin
      st_r   <= st_nxt;
      cnt_r  <= list_nxt.n;
      head_r <= '0;
    end else if (out_fire) begin
      head_r <= head_r + 3'd1;
    end
  end

  // token payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      items_r <= list_nxt.items;
    end
  end

  assign cur = items_r[head_r];

  assign out_chan.valid       = buf_busy;
  assign out_chan.kind        = cur.kind;
  assign out_chan.value       = cur.value;
  assign out_chan.size_class  = cur.size_class;
  assign out_chan.status      = cur.status;
  assign out_chan.expr_done   = cur.expr_done;
  assign out_chan.last_of_run = cur.last_of_run;

endmodule

>>> src/ect_checker.sv
module ect_checker import ect_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  kind,
  input logic [31:0] value,
  input logic [2:0]  status,
  input logic        expr_done,
  input logic        last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("token dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token shown after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != S_OK |-> kind == K_ERR) else $error("status on non error");

  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && value != 32'd0 |-> kind == K_CONST || kind == K_AT || kind == K_VCHAR)
    else $error("stray value");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expr_done |-> last_of_run) else $error("done not on last token");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .kind        (out_chan.kind),
  .value       (out_chan.value),
  .status      (out_chan.status),
  .expr_done   (out_chan.expr_done),
  .last_of_run (out_chan.last_of_run)
);

>>> dv/expression_char_tokenizer_tb.sv
`timescale 1ns / 100ps

module expression_char_tokenizer_tb;
  import ect_pkg::*;

  typedef struct {
    logic [7:0]  ch;
    logic        eot;
    bit          chk;   // typed first token below applies
    kind_t       kind;
    logic [31:0] value;
    status_t     status;
  } char_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  ect_in_if  in_if();
  ect_out_if out_if();
  ect_cfg_if cfg_if();

  expression_char_tokenizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // lexer shadow state, updated as each request is taken
  bit          lx_crlf;
  lex_mode_t   lx_mode;
  logic [31:0] lx_acc;
  logic [15:0] lx_bal;
  logic [5:0]  lx_nlen;
  logic [3:0]  lx_atsz;
  logic        lx_drop;

  tok_t      step_toks[$];   // tokens of the character being lexed
  tok_t      pending_toks[$];
  char_req_t sent_q[$];      // requests driven, not yet taken
  char_req_t gen_q[$];

  int  n_err = 0;
  int  n_chars = 0;
  int  n_toks = 0;
  int  n_exprs = 0;
  int  burst_left = 0;
  bit  hold_req = 0;

  // ---------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------
  function automatic void lx_clear();
    lx_mode = M_IDLE;
    lx_acc  = '0;
    lx_bal  = '0;
    lx_nlen = '0;
    lx_atsz = 4'd2;
    lx_drop = 1'b0;
  endfunction

  function automatic void put_tok(kind_t k, logic [31:0] v, size_t_t sz, status_t st);
    tok_t t;
    if (step_toks.size() >= MaxResults) return;
    t.kind = k;
    t.value = v;
    t.size_class = sz;
    t.status = st;
    t.expr_done = 1'b0;
    t.last_of_run = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void lex_fail(status_t st);
    put_tok(K_ERR, '0, SZ_BYTE, st);
    step_toks[step_toks.size()-1].expr_done = 1'b1;
    lx_drop = 1'b1;
    lx_mode = M_IDLE;
  endfunction

  function automatic void put_const();
    size_t_t sz;
    sz = lx_acc <= 32'hff ? SZ_BYTE : (lx_acc <= 32'hffff ? SZ_WORD : SZ_LONG);
    put_tok(K_CONST, lx_acc, sz, S_OK);
    lx_acc = '0;
    lx_mode = M_IDLE;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_nstart(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == 8'h7f ||
           c == "_" || c == ".";
  endfunction

  function automatic logic [31:0] name_val(logic [7:0] c);
    return c == "." ? 32'h7f : {24'd0, c};
  endfunction

  // a character seen with nothing pending
  function automatic void lex_idle(logic [7:0] c);
    lx_mode = M_IDLE;
    case (c)
      " ", 8'h09: ;
      8'h0a, 8'h0d: if (!lx_crlf) put_tok(K_END, '0, SZ_BYTE, S_OK);
      8'h00: put_tok(K_END, '0, SZ_BYTE, S_OK);
      "'": begin lx_acc = '0; lx_mode = M_STR; end
      "$": begin lx_acc = '0; lx_mode = M_HEX; end
      "%": begin lx_acc = '0; lx_mode = M_BIN; end
      "=": lx_mode = M_EQ;
      "!": lx_mode = M_BANG;
      "<": lx_mode = M_LT;
      ">": lx_mode = M_GT;
      "+": put_tok(K_PLUS, '0, SZ_BYTE, S_OK);
      "-": put_tok(K_MINUS, '0, SZ_BYTE, S_OK);
      "*": put_tok(K_MUL, '0, SZ_BYTE, S_OK);
      "/": put_tok(K_DIV, '0, SZ_BYTE, S_OK);
      "(": begin put_tok(K_LPAR, '0, SZ_BYTE, S_OK); lx_bal++; end
      ")": begin put_tok(K_RPAR, '0, SZ_BYTE, S_OK); lx_bal--; end
      "&": put_tok(K_AND, '0, SZ_BYTE, S_OK);
      "|": put_tok(K_OR, '0, SZ_BYTE, S_OK);
      "^": put_tok(K_XOR, '0, SZ_BYTE, S_OK);
      "\\": put_tok(K_MOD, '0, SZ_BYTE, S_OK);
      "~": put_tok(K_NOT, '0, SZ_BYTE, S_OK);
      "@": begin lx_atsz = 4'd2; lx_mode = M_AT; end
      default: begin
        if (is_dig(c)) begin
          lx_acc = {24'd0, c - 8'd48};
          lx_mode = M_DEC;
        end else if (is_nstart(c)) begin
          put_tok(K_VCHAR, name_val(c), SZ_BYTE, S_OK);
          lx_nlen = 6'd1;
          lx_mode = M_VAR;
        end else begin
          lex_fail(S_BADVAR);
        end
      end
    endcase
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [4:0] hv;
    bit         hex_ok;
    hex_ok = 1'b1;
    if (is_dig(c)) hv = 5'(c - 8'd48);
    else if (c >= "a" && c <= "f") hv = 5'(c - 8'd87);
    else if (c >= "A" && c <= "F") hv = 5'(c - 8'd55);
    else begin hv = '0; hex_ok = 1'b0; end
    case (lx_mode)
      M_DEC:
        if (is_dig(c)) lx_acc = lx_acc * 32'd10 + {24'd0, c - 8'd48};
        else begin put_const(); lex_idle(c); end
      M_HEX:
        if (hex_ok) lx_acc = {lx_acc[27:0], hv[3:0]};
        else if (c != "_") begin put_const(); lex_idle(c); end
      M_BIN:
        if (c == "0" || c == "1") lx_acc = {lx_acc[30:0], c[0]};
        else if (c != "_") begin put_const(); lex_idle(c); end
      M_STR:
        if (c == "'") put_const();
        else if (c == 8'h00) lex_fail(S_SYNTAX);
        else lx_acc = {lx_acc[23:0], c};
      M_EQ, M_BANG:
        if (c == "=") begin
          put_tok(lx_mode == M_EQ ? K_EQ : K_NE, '0, SZ_BYTE, S_OK);
          lx_mode = M_IDLE;
        end else lex_fail(S_MISSING);
      M_LT: begin
        lx_mode = M_IDLE;
        if (c == "<") put_tok(K_SHL, '0, SZ_BYTE, S_OK);
        else if (c == "=") put_tok(K_LE, '0, SZ_BYTE, S_OK);
        else begin put_tok(K_LT, '0, SZ_BYTE, S_OK); lex_idle(c); end
      end
      M_GT: begin
        lx_mode = M_IDLE;
        if (c == ">") put_tok(K_SHR, '0, SZ_BYTE, S_OK);
        else if (c == "=") put_tok(K_GE, '0, SZ_BYTE, S_OK);
        else begin put_tok(K_GT, '0, SZ_BYTE, S_OK); lex_idle(c); end
      end
      M_AT:
        if (c == "(") begin
          put_tok(K_AT, {28'd0, lx_atsz}, SZ_BYTE, S_OK);
          lx_bal++;
          lx_mode = M_IDLE;
        end else if (is_dig(c)) lx_atsz = 4'(c - 8'd48);
      M_VAR:
        if ((is_nstart(c) || is_dig(c)) && lx_nlen < NameMax) begin
          put_tok(K_VCHAR, name_val(c), SZ_BYTE, S_OK);
          lx_nlen = lx_nlen + 6'd1;
        end else begin
          put_tok(K_VEND, '0, SZ_BYTE, S_OK);
          lx_nlen = '0;
          lex_idle(c);
        end
      default: lex_idle(c);
    endcase
  endfunction

  // close whatever token is still open when the text ends
  function automatic void lex_flush();
    case (lx_mode)
      M_DEC, M_HEX, M_BIN: put_const();
      M_STR, M_AT: lex_fail(S_SYNTAX);
      M_EQ, M_BANG: lex_fail(S_MISSING);
      M_LT: put_tok(K_LT, '0, SZ_BYTE, S_OK);
      M_GT: put_tok(K_GT, '0, SZ_BYTE, S_OK);
      M_VAR: put_tok(K_VEND, '0, SZ_BYTE, S_OK);
      default: ;
    endcase
    if (!lx_drop) lx_mode = M_IDLE;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eot);
    step_toks.delete();
    if (lx_drop) begin
      if (eot) lx_clear();
      return;
    end
    lex_char(c);
    if (eot) begin
      if (!lx_drop) lex_flush();
      if (!lx_drop) begin
        put_tok(K_END, '0, SZ_BYTE, S_OK);
        if (lx_bal != 0) lex_fail(S_PARENS);
        else step_toks[step_toks.size()-1].expr_done = 1'b1;
      end
      lx_clear();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // monitors: take requests and config writes, check tokens
  // ---------------------------------------------------------------------
  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    char_req_t r;
    tok_t      e;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) lx_crlf = cfg_if.crlf_as_space;
      if (in_if.valid && in_if.ready) begin
        r = sent_q.pop_front();
        predict_tokens(r.ch, r.eot);
        n_chars++;
        if (r.eot) n_exprs++;
        // directed rows carry a hand-typed first token
        if (r.chk) begin
          if (step_toks.size() == 0) begin
            $display("%0t: no token for %0h, expected kind %s", $time, r.ch, r.kind.name());
            n_err++;
          end else begin
            cmp_field("directed kind", r.kind, step_toks[0].kind);
            cmp_field("directed value", r.value, step_toks[0].value);
            cmp_field("directed status", r.status, step_toks[0].status);
          end
        end
        foreach (step_toks[i]) pending_toks.push_back(step_toks[i]);
      end
      if (out_if.valid && out_if.ready) begin
        n_toks++;
        if (pending_toks.size() == 0) begin
          $display("%0t: unexpected token, kind %0d value %0h", $time, out_if.kind,
                   out_if.value);
          n_err++;
        end else begin
          e = pending_toks.pop_front();
          cmp_field("kind", e.kind, out_if.kind);
          cmp_field("value", e.value, out_if.value);
          cmp_field("size_class", e.size_class, out_if.size_class);
          cmp_field("status", e.status, out_if.status);
          cmp_field("expr_done", e.expr_done, out_if.expr_done);
          cmp_field("last_of_run", e.last_of_run, out_if.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // token receiver: rotating stall patterns plus one long hold-off
  // ---------------------------------------------------------------------
  int rx_cyc = 0;
  int hold_left = 0;
  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_req) begin
      hold_req = 0;
      hold_left = 90;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case ((rx_cyc / 150) % 3)
        0: out_if.ready <= 1'b1;                          // no stalls
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((rx_cyc % 7) >= 3);     // periodic bursts of stall
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------
  task automatic send_char(char_req_t r);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    sent_q.push_back(r);
    in_if.valid <= 1'b1;
    in_if.ch <= r.ch;
    in_if.end_of_text <= r.eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_crlf(bit v);
    cfg_if.valid <= 1'b1;
    cfg_if.crlf_as_space <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // block idle: all tokens back, then an extra wait for a silent last character
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_toks.size() != 0 || sent_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // random expression text
  // ---------------------------------------------------------------------
  function automatic void add_ch(logic [7:0] c);
    char_req_t r;
    r.ch = c;
    r.eot = 1'b0;
    r.chk = 1'b0;
    r.kind = K_END;
    r.value = '0;
    r.status = S_OK;
    gen_q.push_back(r);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_ch(s[i]);
  endfunction

  function automatic logic [7:0] rand_name_ch(bit first);
    string nc;
    nc = "abcxyzAQZ_.";
    if (!first && $urandom_range(0, 3) == 0) return 8'd48 + 8'($urandom_range(0, 9));
    if ($urandom_range(0, 15) == 0) return 8'h7f;
    return nc[$urandom_range(0, nc.len() - 1)];
  endfunction

  function automatic void gen_expr();
    string ops[19];
    string hx;
    int    opened;
    int    n;
    ops = '{"+", "-", "*", "/", "&", "|", "^", "\\", "~", "<", "<=", "<<", ">", ">=",
            ">>", "==", "!=", "=", "!"};
    hx = "0123456789abcdefABCDEF_";
    opened = 0;
    repeat ($urandom_range(1, 7)) begin
      case ($urandom_range(0, 13))
        0, 1: add_str($sformatf("%0d", $urandom_range(0, 99999)));
        2: add_str($sformatf("%0d", $urandom()));          // spans the full 32-bit range
        3: begin
          add_ch("$");
          repeat ($urandom_range(1, 10)) add_ch(hx[$urandom_range(0, hx.len() - 1)]);
        end
        4: begin
          add_ch("%");
          repeat ($urandom_range(1, 20)) add_ch("0" + 8'($urandom_range(0, 2)));
        end
        5: begin
          add_ch("'");
          repeat ($urandom_range(0, 5)) add_ch(8'($urandom_range(1, 255)));
          if ($urandom_range(0, 7) != 0) add_ch("'");
        end
        6, 7: add_str(ops[$urandom_range(0, 18)]);
        8: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
          add_ch(rand_name_ch(1));
          repeat (n - 1) add_ch(rand_name_ch(0));
        end
        9: begin
          add_ch("(");
          opened++;
        end
        10: if (opened > 0) begin
          add_ch(")");
          opened--;
        end
        11: begin
          add_ch("@");
          repeat ($urandom_range(0, 2)) add_ch(8'($urandom_range(33, 126)));
          if ($urandom_range(0, 5) != 0) add_ch("(");
          opened++;
        end
        12: add_ch(8'($urandom_range(0, 255)));             // noise
        default: begin
          case ($urandom_range(0, 4))
            0: add_ch(8'h0d);
            1: add_ch(8'h0a);
            2: add_ch(8'h09);
            3: add_ch(8'h00);
            default: add_ch(" ");
          endcase
        end
      endcase
      if ($urandom_range(0, 2) == 0) add_ch(" ");
    end
    // mostly close the brackets so the end of text is reached cleanly
    if ($urandom_range(0, 4) != 0) repeat (opened) add_ch(")");
    gen_q[gen_q.size()-1].eot = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // directed rows; first token typed where it is obvious
  // ---------------------------------------------------------------------
  char_req_t dir_tab[25] = '{
    '{"+",   1'b0, 1'b1, K_PLUS,  32'd0,    S_OK},
    '{"9",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"<",   1'b0, 1'b1, K_CONST, 32'd9,    S_OK},
    '{"<",   1'b0, 1'b1, K_SHL,   32'd0,    S_OK},
    '{"=",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"x",   1'b1, 1'b1, K_ERR,   32'd0,    S_MISSING},   // lone equals
    '{"$",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"F",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"_",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"f",   1'b1, 1'b1, K_CONST, 32'hff,   S_OK},
    '{"'",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{8'hff, 1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{8'h00, 1'b1, 1'b1, K_ERR,   32'd0,    S_SYNTAX},    // nul inside a quote
    '{8'h80, 1'b1, 1'b1, K_ERR,   32'd0,    S_BADVAR},
    '{"@",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"4",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"(",   1'b1, 1'b1, K_AT,    32'd4,    S_OK},        // then end and bad balance
    '{"%",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"1",   1'b0, 1'b0, K_END,   32'd0,    S_OK},
    '{"2",   1'b1, 1'b1, K_CONST, 32'd1,    S_OK},
    '{".",   1'b0, 1'b1, K_VCHAR, 32'h7f,   S_OK},
    '{"!",   1'b0, 1'b1, K_VEND,  32'd0,    S_OK},
    '{"=",   1'b0, 1'b1, K_NE,    32'd0,    S_OK},
    '{8'h0d, 1'b0, 1'b1, K_END,   32'd0,    S_OK},
    '{"~",   1'b1, 1'b1, K_NOT,   32'd0,    S_OK}
  };

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  bit crlf_plan[4] = '{1'b0, 1'b1, 1'b0, 1'b1};

  initial begin
    int phase_chars;
    in_if.valid = 1'b0;
    in_if.ch = '0;
    in_if.end_of_text = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.crlf_as_space = 1'b0;
    lx_crlf = 1'b0;
    lx_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (crlf_plan[p]) begin
      write_crlf(crlf_plan[p]);
      if (p == 0) foreach (dir_tab[i]) send_char(dir_tab[i]);
      phase_chars = 0;
      // long receiver hold-off so the buffer fills and the input backs up
      if (p == 1) hold_req = 1;
      while (phase_chars < 60) begin
        gen_q.delete();
        gen_expr();
        foreach (gen_q[i]) send_char(gen_q[i]);
        phase_chars += gen_q.size();
      end
      wait_idle();
    end

    $display("tb: %0d characters in %0d expressions lexed, %0d tokens checked",
             n_chars, n_exprs, n_toks);
    $display("tb: both crlf settings used, receiver stalls and one long hold-off applied");
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: timeout with %0d tokens outstanding", pending_toks.size());
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
src/ect_pkg.sv
src/ect_chan_if.sv
src/ect_lex.sv
src/expression_char_tokenizer.sv
src/ect_checker.sv
dv/expression_char_tokenizer_tb.sv
